FILE: rtl/hqmc_pkg.sv
`default_nettype none

package hqmc_pkg;

  localparam int HQMC_MAX_WIDTH = 1024;
  localparam int HQMC_ROWS_LIMIT = 1024;
  localparam int HQMC_REG_W = 11;

  typedef enum logic {
    CFG_ROI_WIDTH  = 1'b0,
    CFG_ROI_HEIGHT = 1'b1
  } cfg_index_t;

  localparam logic [7:0] SEG_A_END = 8'd51;
  localparam logic [7:0] SEG_B_BASE = 8'd52;
  localparam logic [7:0] SEG_B_END = 8'd102;
  localparam logic [7:0] SEG_C_BASE = 8'd103;
  localparam logic [7:0] SEG_C_END = 8'd153;
  localparam logic [7:0] SEG_D_BASE = 8'd154;
  localparam logic [7:0] SEG_D_END = 8'd203;
  localparam logic [7:0] SEG_E_BASE = 8'd204;
  localparam logic [7:0] FULL_SCALE = 8'd255;

  typedef struct packed {
    logic signed [9:0] col_offset;
    logic signed [9:0] row_offset;
    logic [7:0]        px;
    logic [7:0]        lf;
    logic              produce;
    logic              last;
  } cell_word_t;

endpackage

`default_nettype wire

FILE: rtl/hqmc_ram.sv
`default_nettype none

module hqmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/hqmc_cell.sv
`default_nettype none

module hqmc_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire hqmc_pkg::cell_word_t word,
  input  wire logic [7:0]         up,
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [9:0]       out_col_offset,
  output logic signed [9:0]       out_row_offset,
  output logic [7:0]              out_height_here,
  output logic [7:0]              out_height_left,
  output logic [7:0]              out_height_up_left,
  output logic [7:0]              out_height_up,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic                    out_frame_last
);

  import hqmc_pkg::*;

  cell_word_t s1_r;
  logic       s1_valid_r;
  logic [7:0] ul_r;
  logic       out_valid_r;
  logic       adv;
  logic [7:0] m;
  logic [7:0] d;
  logic [7:0] d5;
  logic [7:0] red_nxt;
  logic [7:0] green_nxt;
  logic [7:0] blue_nxt;

  assign adv = s1_valid_r && (!out_valid_r || !out_stall);
  assign free = !s1_valid_r || adv;

  always_comb begin
    m = s1_r.px;
    if (s1_r.lf > m) m = s1_r.lf;
    if (ul_r > m) m = ul_r;
    if (up > m) m = up;
    if (m <= SEG_A_END) begin
      d = m;
    end else if (m <= SEG_B_END) begin
      d = m - SEG_B_BASE;
    end else if (m <= SEG_C_END) begin
      d = m - SEG_C_BASE;
    end else if (m <= SEG_D_END) begin
      d = m - SEG_D_BASE;
    end else begin
      d = m - SEG_E_BASE;
    end
    d5 = {d[5:0], 2'b00} + d;
    if (m <= SEG_A_END) begin
      red_nxt = FULL_SCALE;
      green_nxt = d5;
      blue_nxt = 8'd0;
    end else if (m <= SEG_B_END) begin
      red_nxt = FULL_SCALE - d5;
      green_nxt = FULL_SCALE;
      blue_nxt = 8'd0;
    end else if (m <= SEG_C_END) begin
      red_nxt = 8'd0;
      green_nxt = FULL_SCALE;
      blue_nxt = d5;
    end else if (m <= SEG_D_END) begin
      red_nxt = 8'd0;
      green_nxt = FULL_SCALE - d5;
      blue_nxt = FULL_SCALE;
    end else begin
      red_nxt = d5;
      green_nxt = 8'd0;
      blue_nxt = FULL_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      ul_r <= 8'd0;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        ul_r <= up;
        out_valid_r <= s1_r.produce;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= word;
    end
    if (adv) begin
      out_col_offset <= s1_r.col_offset;
      out_row_offset <= s1_r.row_offset;
      out_height_here <= s1_r.px;
      out_height_left <= s1_r.lf;
      out_height_up_left <= ul_r;
      out_height_up <= up;
      out_red <= red_nxt;
      out_green <= green_nxt;
      out_blue <= blue_nxt;
      out_frame_last <= s1_r.last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/heightmap_quad_mesh_colormap.sv
`default_nettype none

// Height-map mesh generator: takes 8-bit pixels in raster order and, for every pixel from
// row 1 and column 1 on, delivers one mesh cell with centered offsets, the four corner
// heights and a rainbow false color of the 2x2 window maximum. A new pixel is taken every
// cycle that in_stall is low. The line store is read at the edge that takes a pixel, the
// color is formed from that read and the word in the color stage, and the cell is
// registered when that stage advances, which out_stall can hold off. While a cell waits
// under out_stall, one more word is held in the color stage and the input stalls behind
// it. The line store is one memory of MAX_WIDTH entries, read and written once per pixel.
// Width and height are clamped to 2..MAX_WIDTH and 2..1024; the counters wrap at the
// end of a region on their own, and frame_start forces column 0, row 0.
module heightmap_quad_mesh_colormap #(
  parameter int MAX_WIDTH = hqmc_pkg::HQMC_MAX_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_pixel,
  input  wire logic                         in_frame_start,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [9:0]                 out_col_offset,
  output logic signed [9:0]                 out_row_offset,
  output logic [7:0]                        out_height_here,
  output logic [7:0]                        out_height_left,
  output logic [7:0]                        out_height_up_left,
  output logic [7:0]                        out_height_up,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic                              out_frame_last,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [hqmc_pkg::HQMC_REG_W-1:0] cfg_wdata
);

  import hqmc_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > HQMC_REG_W) ? CW : HQMC_REG_W;
  localparam int DW = ((CW > 10) ? CW : 10) + 1;

  logic [HQMC_REG_W-1:0] roi_width_r;
  logic [HQMC_REG_W-1:0] roi_height_r;
  logic [XW-1:0]         col_r;
  logic [XW-1:0]         col_nxt;
  logic [9:0]            row_r;
  logic [9:0]            row_nxt;
  logic [7:0]            left_r;

  logic [WW-1:0]         w_ext;
  logic [CW-1:0]         w_eff;
  logic [10:0]           h_eff;
  logic [XW-1:0]         col_sel;
  logic [9:0]            row_sel;
  logic [10:0]           row_inc;
  logic [XW-1:0]         c;
  logic [9:0]            r;
  logic [CW-1:0]         c_plus;
  logic [10:0]           r_plus;
  logic [DW-1:0]         col_diff;
  logic [10:0]           row_diff;
  logic                  in_accept;
  logic                  free;
  logic [7:0]            up;
  cell_word_t            word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roi_width_r <= HQMC_REG_W'(1024);
      roi_height_r <= HQMC_REG_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROI_WIDTH:  roi_width_r <= cfg_wdata;
        CFG_ROI_HEIGHT: roi_height_r <= cfg_wdata;
        default:        roi_height_r <= roi_height_r;
      endcase
    end
  end

  always_comb begin
    w_ext = WW'(roi_width_r);
    if (w_ext < WW'(2)) begin
      w_eff = CW'(2);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(w_ext);
    end
    if (roi_height_r < 11'd2) begin
      h_eff = 11'd2;
    end else if (roi_height_r > 11'(HQMC_ROWS_LIMIT)) begin
      h_eff = 11'(HQMC_ROWS_LIMIT);
    end else begin
      h_eff = roi_height_r;
    end
  end

  always_comb begin
    col_sel = in_frame_start ? '0 : col_r;
    row_sel = in_frame_start ? '0 : row_r;
    if (CW'(col_sel) >= w_eff) begin
      c = '0;
      row_inc = {1'b0, row_sel} + 11'd1;
    end else begin
      c = col_sel;
      row_inc = {1'b0, row_sel};
    end
    r = (row_inc >= h_eff) ? 10'd0 : row_inc[9:0];

    c_plus = CW'(c) + CW'(1);
    r_plus = {1'b0, r} + 11'd1;
    if (c_plus >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_plus >= h_eff) ? 10'd0 : r_plus[9:0];
    end else begin
      col_nxt = XW'(c_plus);
      row_nxt = r;
    end

    col_diff = DW'(c) - DW'(w_eff >> 1);
    row_diff = {1'b0, r} - (h_eff >> 1);
    word.col_offset = col_diff[9:0];
    word.row_offset = row_diff[9:0];
    word.px = in_pixel;
    word.lf = left_r;
    word.produce = (c != '0) && (r != 10'd0);
    word.last = (c_plus == w_eff) && (r_plus == h_eff);
  end

  assign in_stall = !free;
  assign in_accept = in_valid && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= 10'd0;
      left_r <= 8'd0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      left_r <= in_pixel;
    end
  end

  hqmc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH)
  ) u_row_store (
    .clk  (clk),
    .we   (in_accept),
    .waddr(c),
    .wdata(in_pixel),
    .re   (in_accept),
    .raddr(c),
    .rdata(up)
  );

  hqmc_cell u_cell (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (in_accept),
    .word              (word),
    .up                (up),
    .free              (free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_col_offset    (out_col_offset),
    .out_row_offset    (out_row_offset),
    .out_height_here   (out_height_here),
    .out_height_left   (out_height_left),
    .out_height_up_left(out_height_up_left),
    .out_height_up     (out_height_up),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_frame_last    (out_frame_last)
  );

endmodule

`default_nettype wire

FILE: sim/tb_heightmap_quad_mesh_colormap.sv
`timescale 1ns / 1ps

module tb_heightmap_quad_mesh_colormap;
  import hqmc_pkg::*;

  typedef struct {
    logic [7:0] pixel;
    logic       start;
  } pixel_word_t;

  typedef struct {
    logic signed [9:0] col_off;
    logic signed [9:0] row_off;
    logic [7:0]        here;
    logic [7:0]        left;
    logic [7:0]        up_left;
    logic [7:0]        up;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last;
  } mesh_cell_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_pixel = 8'd0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [9:0]     out_col_offset;
  logic signed [9:0]     out_row_offset;
  logic [7:0]            out_height_here;
  logic [7:0]            out_height_left;
  logic [7:0]            out_height_up_left;
  logic [7:0]            out_height_up;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  out_frame_last;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_ROI_WIDTH;
  logic [HQMC_REG_W-1:0] cfg_wdata = '0;

  heightmap_quad_mesh_colormap uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel           (in_pixel),
    .in_frame_start     (in_frame_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_col_offset     (out_col_offset),
    .out_row_offset     (out_row_offset),
    .out_height_here    (out_height_here),
    .out_height_left    (out_height_left),
    .out_height_up_left (out_height_up_left),
    .out_height_up      (out_height_up),
    .out_red            (out_red),
    .out_green          (out_green),
    .out_blue           (out_blue),
    .out_frame_last     (out_frame_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  pixel_word_t           pixel_queue[$];
  mesh_cell_t            cell_queue[$];
  mesh_cell_t            want;
  pixel_word_t           nxt;

  logic [HQMC_REG_W-1:0] roi_w = 11'd1024;
  logic [HQMC_REG_W-1:0] roi_h = 11'd1024;
  logic [7:0]            line_mem [HQMC_MAX_WIDTH];
  logic [7:0]            left_q = 8'd0;
  logic [7:0]            up_left_q = 8'd0;
  int                    col_cnt = 0;
  int                    row_cnt = 0;

  int                    mismatches = 0;
  int                    pixels_taken = 0;
  int                    cells_seen = 0;
  int                    tx_gap = 0;
  int                    rx_wait = 0;
  int                    rx_hold = 0;
  bit                    tx_idle = 1'b1;
  bit                    rx_idle = 1'b1;
  bit                    px_accept;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int eff_dim(logic [HQMC_REG_W-1:0] v, int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [7:0] edge_val(int k);
    case (k)
      0: return 8'd0;
      1: return SEG_A_END;
      2: return SEG_B_BASE;
      3: return SEG_B_END;
      4: return SEG_C_BASE;
      5: return SEG_C_END;
      6: return SEG_D_BASE;
      7: return SEG_D_END;
      8: return SEG_E_BASE;
      default: return FULL_SCALE;
    endcase
  endfunction

  function automatic logic [7:0] pick_pixel();
    if ($urandom_range(0, 7) == 0) return edge_val($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [HQMC_REG_W-1:0] rand_dim();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return 11'($urandom_range(2, 24));
    if (sel < 16) return 11'($urandom_range(0, 1));
    if (sel < 18) return 11'($urandom_range(25, 120));
    return 11'($urandom_range(1025, 2047));
  endfunction

  task automatic take_pixel(input logic [7:0] px, input logic fs);
    int         w;
    int         h;
    int         c;
    int         r;
    int         m;
    logic [7:0] up;
    logic [7:0] ul;
    logic [7:0] lf;
    mesh_cell_t exp_cell;
    w = eff_dim(roi_w, HQMC_MAX_WIDTH);
    h = eff_dim(roi_h, HQMC_ROWS_LIMIT);
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    c = col_cnt;
    r = row_cnt;
    up = line_mem[c];
    ul = up_left_q;
    lf = left_q;
    if (c >= 1 && r >= 1) begin
      m = int'(px);
      if (int'(lf) > m) m = int'(lf);
      if (int'(ul) > m) m = int'(ul);
      if (int'(up) > m) m = int'(up);
      if (m <= SEG_A_END) begin
        exp_cell.red = FULL_SCALE;
        exp_cell.green = 8'(m * 5);
        exp_cell.blue = 8'd0;
      end else if (m <= SEG_B_END) begin
        exp_cell.red = 8'(FULL_SCALE - (m - SEG_B_BASE) * 5);
        exp_cell.green = FULL_SCALE;
        exp_cell.blue = 8'd0;
      end else if (m <= SEG_C_END) begin
        exp_cell.red = 8'd0;
        exp_cell.green = FULL_SCALE;
        exp_cell.blue = 8'((m - SEG_C_BASE) * 5);
      end else if (m <= SEG_D_END) begin
        exp_cell.red = 8'd0;
        exp_cell.green = 8'(FULL_SCALE - (m - SEG_D_BASE) * 5);
        exp_cell.blue = FULL_SCALE;
      end else begin
        exp_cell.red = 8'((m - SEG_E_BASE) * 5);
        exp_cell.green = 8'd0;
        exp_cell.blue = FULL_SCALE;
      end
      exp_cell.col_off = 10'(c - w / 2);
      exp_cell.row_off = 10'(r - h / 2);
      exp_cell.here = px;
      exp_cell.left = lf;
      exp_cell.up_left = ul;
      exp_cell.up = up;
      exp_cell.last = (c == w - 1) && (r == h - 1);
      cell_queue.push_back(exp_cell);
    end
    line_mem[c] = px;
    up_left_q = up;
    left_q = px;
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  function automatic void check_field(string name, logic [9:0] exp_v, logic [9:0] act_v);
    if (act_v !== exp_v) begin
      if (mismatches < 50) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_pixel <= 8'd0;
      in_frame_start <= 1'b0;
      tx_gap = 0;
    end else begin
      px_accept = in_valid && !in_stall;
      if (px_accept) begin
        take_pixel(in_pixel, in_frame_start);
        pixels_taken++;
        if (pixels_taken % 64 == 0) tx_idle = ($urandom_range(0, 2) != 0);
        tx_gap = tx_idle ? $urandom_range(0, 5) : 0;
      end
      if (!in_valid || px_accept) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap--;
        end else if (pixel_queue.size() != 0) begin
          nxt = pixel_queue.pop_front();
          in_pixel <= nxt.pixel;
          in_frame_start <= nxt.start;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cell_queue.size() == 0) begin
          if (mismatches < 50) begin
            $display("%0t: no cell expected, actual col_offset %0d row_offset %0d",
                     $time, out_col_offset, out_row_offset);
          end
          mismatches++;
        end else begin
          want = cell_queue.pop_front();
          check_field("col_offset", want.col_off, out_col_offset);
          check_field("row_offset", want.row_off, out_row_offset);
          check_field("height_here", 10'(want.here), 10'(out_height_here));
          check_field("height_left", 10'(want.left), 10'(out_height_left));
          check_field("height_up_left", 10'(want.up_left), 10'(out_height_up_left));
          check_field("height_up", 10'(want.up), 10'(out_height_up));
          check_field("red", 10'(want.red), 10'(out_red));
          check_field("green", 10'(want.green), 10'(out_green));
          check_field("blue", 10'(want.blue), 10'(out_blue));
          check_field("frame_last", 10'(want.last), 10'(out_frame_last));
        end
        cells_seen++;
        if (cells_seen % 64 == 0) rx_idle = ($urandom_range(0, 2) != 0);
        rx_wait = rx_idle ? $urandom_range(0, 5) : 0;
        // A long hold-off lets the pipeline fill so that the input side stalls.
        if (cells_seen == 30) rx_hold = 400;
      end
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic drain();
    while (pixel_queue.size() != 0 || in_valid || cell_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [HQMC_REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROI_WIDTH) begin
      roi_w = val;
    end else begin
      roi_h = val;
    end
  endtask

  task automatic run_phase(input logic [HQMC_REG_W-1:0] w_val,
                           input logic [HQMC_REG_W-1:0] h_val,
                           input int n, input bit restart, input bit pause_mid);
    pixel_word_t wd;
    bit          fresh;
    drain();
    // A wider row would read line store entries that this region never wrote.
    fresh = restart || (eff_dim(w_val, HQMC_MAX_WIDTH) > eff_dim(roi_w, HQMC_MAX_WIDTH));
    write_reg(CFG_ROI_WIDTH, w_val);
    write_reg(CFG_ROI_HEIGHT, h_val);
    for (int i = 0; i < n; i++) begin
      wd.pixel = pick_pixel();
      wd.start = (i == 0) ? fresh : ((n < 200) && ($urandom_range(0, 99) == 0));
      pixel_queue.push_back(wd);
      if (pause_mid && i == n / 2) drain();
    end
  endtask

  initial begin
    pixel_word_t wd;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Two columns and a falling staircase put every color segment edge on the window maximum.
    write_reg(CFG_ROI_WIDTH, 11'd1);
    write_reg(CFG_ROI_HEIGHT, 11'd11);
    for (int k = 10; k >= 0; k--) begin
      for (int j = 0; j < 2; j++) begin
        wd.pixel = (k == 0) ? 8'd0 : edge_val(k - 1);
        wd.start = (k == 10 && j == 0);
        pixel_queue.push_back(wd);
      end
    end
    for (int j = 0; j < 4; j++) begin
      wd.pixel = pick_pixel();
      wd.start = 1'b0;
      pixel_queue.push_back(wd);
    end

    // Shrinking the region mid-row leaves both counters past their new bounds.
    run_phase(11'd6, 11'd4, 15, 1'b1, 1'b0);
    run_phase(11'd3, 11'd2, 8, 1'b0, 1'b0);

    // The largest register values clamp both dimensions to their upper bounds.
    run_phase(11'd2047, 11'd2047, 1060, 1'b1, 1'b0);
    run_phase(11'd0, 11'd0, 12, 1'b1, 1'b0);

    for (int p = 0; p < 8; p++) begin
      run_phase(rand_dim(), rand_dim(), $urandom_range(20, 36), 1'($urandom_range(0, 1)),
                p == 3);
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && cell_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
